/* rtl/rlcm_pkg.sv */
// Package for the running LCM block: constants, state and unit codes,
// and the request and response structs of the shared arithmetic unit.
// No dependencies.
package rlcm_pkg;

  localparam int unsigned MAX_ITEMS = 16;
  localparam int unsigned CNT_W = 9;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned LCM_W = 63;
  localparam logic [LCM_W-1:0] LCM_MAX = {LCM_W{1'b1}};
  localparam logic [WORD_W-1:0] HUNDRED = 64'd100;
  localparam logic [7:0] SCALE_HUNDREDTHS = 8'd100;
  localparam logic [7:0] SCALE_DAYS = 8'd1;

  typedef enum logic {
    ALU_DIV,
    ALU_MUL
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FOLD,
    ST_GCD,
    ST_GCD_WAIT,
    ST_Q_WAIT,
    ST_MUL_START,
    ST_MUL_WAIT,
    ST_NEXT,
    ST_FIN,
    ST_FIN_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    alu_op_t op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [WORD_W-1:0] quo;
    logic [WORD_W-1:0] rem;
    logic [LCM_W-1:0] prod;
    logic ovf;
  } alu_rsp_t;

endpackage

/* rtl/rlcm_in_if.sv */
// Input channel of the running LCM block: valid, ready and one period item.
// Depends on nothing.
interface rlcm_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] period;
  logic [7:0] scale;
  logic last_item;

  modport source(output valid, period, scale, last_item, input ready);
  modport sink(input valid, period, scale, last_item, output ready);
endinterface

/* rtl/rlcm_out_if.sv */
// Result channel of the running LCM block: valid, ready and one result item.
// Depends on nothing.
interface rlcm_out_if;
  logic valid;
  logic ready;
  logic [62:0] recur_days;
  logic [8:0] items_used;
  logic overflowed;

  modport source(output valid, recur_days, items_used, overflowed, input ready);
  modport sink(input valid, recur_days, items_used, overflowed, output ready);
endinterface

/* rtl/running_lcm_of_periods_core.sv */
// Top level of the running LCM block: sequencer, running state and result
// register around the shared arithmetic unit.
// Depends on rlcm_pkg, rlcm_in_if, rlcm_out_if and rlcm_alu.
//
// Usage: period items arrive on in_ch with valid/ready; an item is taken
// when both are high. Each item is folded into a plain and a promoted LCM
// with Euclid's algorithm, one division per remainder step, then a division
// and a multiplication, all on one shared unit. The first item of a run
// only loads both LCMs without the unit; in_ch ready is low while an item
// is folded. An item marked last adds one division by 100 when hundredths
// were seen, then loads the result register on out_ch. While the receiver
// stalls, the result waits there and later items are still taken; only the
// next last item waits until the register is free.
// Reset clears the run and the result register. Items past the cap of 16
// are counted for nothing but still end the run.
module running_lcm_of_periods_core
  import rlcm_pkg::*;
(
  input logic clk,
  input logic rst_n,
  rlcm_in_if.sink in_ch,
  rlcm_out_if.source out_ch
);

  state_t state_r, state_nxt;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic [LCM_W-1:0] lcm_plain_r, lcm_prom_r, ga_r, gb_r, v_r, q_r, fin_r;
  logic [LCM_W-1:0] p_plain_r, p_prom_r;
  logic ovf_plain_r, ovf_prom_r, saw_r, last_r, sel_r;
  logic [CNT_W-1:0] cnt_r;
  logic out_valid_r;
  logic [LCM_W-1:0] out_lcm_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic out_ovf_r;

  logic accept;
  logic [31:0] raw;
  logic [LCM_W-1:0] p_in;
  logic [LCM_W-1:0] cur_acc;
  logic cur_ovf;
  logic res_ovf;

  rlcm_alu u_alu (
    .clk(clk),
    .rst_n(rst_n),
    .req(alu_req),
    .rsp(alu_rsp)
  );

  assign accept = in_ch.valid && in_ch.ready;
  assign raw = in_ch.period;
  assign p_in = (raw[31] || raw == '0) ? LCM_W'(1) : LCM_W'(raw);
  assign cur_acc = sel_r ? lcm_prom_r : lcm_plain_r;
  assign cur_ovf = sel_r ? ovf_prom_r : ovf_plain_r;
  assign res_ovf = saw_r ? ovf_prom_r : ovf_plain_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (cnt_r < CNT_W'(MAX_ITEMS)) state_nxt = ST_FOLD;
          else if (in_ch.last_item) state_nxt = ST_FIN;
        end
      end
      ST_FOLD: state_nxt = (cur_ovf || cur_acc == '0) ? ST_NEXT : ST_GCD;
      ST_GCD: state_nxt = (gb_r == '0) ? ST_Q_WAIT : ST_GCD_WAIT;
      ST_GCD_WAIT: if (alu_rsp.done) state_nxt = ST_GCD;
      ST_Q_WAIT: if (alu_rsp.done) state_nxt = ST_MUL_START;
      ST_MUL_START: state_nxt = ST_MUL_WAIT;
      ST_MUL_WAIT: if (alu_rsp.done) state_nxt = ST_NEXT;
      ST_NEXT: begin
        if (!sel_r) state_nxt = ST_FOLD;
        else if (last_r) state_nxt = ST_FIN;
        else state_nxt = ST_IDLE;
      end
      ST_FIN: state_nxt = saw_r ? ST_FIN_WAIT : ST_OUT;
      ST_FIN_WAIT: if (alu_rsp.done) state_nxt = ST_OUT;
      ST_OUT: if (!out_valid_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op = ALU_DIV;
    alu_req.a = '0;
    alu_req.b = '0;
    case (state_r)
      ST_GCD: begin
        alu_req.start = 1'b1;
        if (gb_r == '0) begin
          alu_req.a = {1'b0, cur_acc};
          alu_req.b = {1'b0, ga_r};
        end else begin
          alu_req.a = {1'b0, ga_r};
          alu_req.b = {1'b0, gb_r};
        end
      end
      ST_MUL_START: begin
        alu_req.start = 1'b1;
        alu_req.op = ALU_MUL;
        alu_req.a = {1'b0, q_r};
        alu_req.b = {1'b0, v_r};
      end
      ST_FIN: begin
        alu_req.start = saw_r;
        alu_req.a = {1'b0, lcm_prom_r};
        alu_req.b = HUNDRED;
      end
      default: alu_req.start = 1'b0;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lcm_plain_r <= '0;
      lcm_prom_r <= '0;
      ovf_plain_r <= 1'b0;
      ovf_prom_r <= 1'b0;
      saw_r <= 1'b0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_ch.scale == SCALE_HUNDREDTHS) saw_r <= 1'b1;
            last_r <= in_ch.last_item;
            sel_r <= 1'b0;
            if (cnt_r < CNT_W'(MAX_ITEMS)) begin
              cnt_r <= cnt_r + CNT_W'(1);
              p_plain_r <= p_in;
              p_prom_r <= (in_ch.scale == SCALE_DAYS) ? LCM_W'(p_in * LCM_W'(100)) : p_in;
            end
          end
        end
        ST_FOLD: begin
          v_r <= sel_r ? p_prom_r : p_plain_r;
          ga_r <= cur_acc;
          gb_r <= sel_r ? p_prom_r : p_plain_r;
          if (!cur_ovf && cur_acc == '0) begin
            if (sel_r) lcm_prom_r <= p_prom_r;
            else lcm_plain_r <= p_plain_r;
          end
        end
        ST_GCD_WAIT: begin
          if (alu_rsp.done) begin
            ga_r <= gb_r;
            gb_r <= alu_rsp.rem[LCM_W-1:0];
          end
        end
        ST_Q_WAIT: if (alu_rsp.done) q_r <= alu_rsp.quo[LCM_W-1:0];
        ST_MUL_WAIT: begin
          if (alu_rsp.done) begin
            if (sel_r) begin
              lcm_prom_r <= alu_rsp.ovf ? LCM_MAX : alu_rsp.prod;
              ovf_prom_r <= alu_rsp.ovf;
            end else begin
              lcm_plain_r <= alu_rsp.ovf ? LCM_MAX : alu_rsp.prod;
              ovf_plain_r <= alu_rsp.ovf;
            end
          end
        end
        ST_NEXT: sel_r <= 1'b1;
        ST_FIN: fin_r <= lcm_plain_r;
        ST_FIN_WAIT: if (alu_rsp.done) fin_r <= alu_rsp.quo[LCM_W-1:0];
        ST_OUT: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            out_lcm_r <= res_ovf ? LCM_MAX : fin_r;
            out_cnt_r <= cnt_r;
            out_ovf_r <= res_ovf;
            lcm_plain_r <= '0;
            lcm_prom_r <= '0;
            ovf_plain_r <= 1'b0;
            ovf_prom_r <= 1'b0;
            saw_r <= 1'b0;
            cnt_r <= '0;
          end
        end
        default: sel_r <= sel_r;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.recur_days = out_lcm_r;
  assign out_ch.items_used = out_cnt_r;
  assign out_ch.overflowed = out_ovf_r;

  a_alu_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !alu_rsp.busy) else $error("unit busy while idle");
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ITEMS)) else $error("item count past cap");
  a_plain_sat: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_plain_r |-> lcm_plain_r == LCM_MAX) else $error("plain chain not saturated");
  a_prom_sat: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_prom_r |-> lcm_prom_r == LCM_MAX) else $error("promoted chain not saturated");

endmodule

/* rtl/rlcm_alu.sv */
// Shared arithmetic unit: bit-serial 64-bit division (one quotient bit per
// cycle) and shift-add multiplication with saturation detection.
// Depends on rlcm_pkg.
module rlcm_alu
  import rlcm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic busy_r, done_r, big_r, ovf_r;
  alu_op_t op_r;
  logic [5:0] cnt_r;
  logic [WORD_W-1:0] x_r, y_r;
  logic [WORD_W:0] acc_r;
  logic [WORD_W:0] rs;
  logic ge;
  logic [WORD_W-1:0] sum;

  always_comb begin
    rs = {acc_r[WORD_W-1:0], x_r[WORD_W-1]};
    ge = rs >= {1'b0, y_r};
    sum = acc_r[WORD_W-1:0] + x_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && req.start) begin
        busy_r <= 1'b1;
        op_r <= req.op;
        x_r <= req.a;
        y_r <= req.b;
        acc_r <= '0;
        cnt_r <= '0;
        big_r <= 1'b0;
        ovf_r <= 1'b0;
      end else if (busy_r) begin
        case (op_r)
          ALU_DIV: begin
            acc_r <= ge ? (rs - {1'b0, y_r}) : rs;
            x_r <= {x_r[WORD_W-2:0], ge};
            cnt_r <= cnt_r + 6'd1;
            if (cnt_r == 6'd63) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          ALU_MUL: begin
            if (y_r == '0 || ovf_r) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end else begin
              if (y_r[0]) begin
                acc_r <= {1'b0, sum};
                if (big_r || sum[WORD_W-1]) ovf_r <= 1'b1;
              end
              big_r <= big_r | x_r[WORD_W-2];
              x_r <= {x_r[WORD_W-2:0], 1'b0};
              y_r <= {1'b0, y_r[WORD_W-1:1]};
            end
          end
          default: busy_r <= 1'b0;
        endcase
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo = x_r;
  assign rsp.rem = acc_r[WORD_W-1:0];
  assign rsp.prod = acc_r[LCM_W-1:0];
  assign rsp.ovf = ovf_r;

endmodule

/* test/tb_channels.sv */
`timescale 1ns / 100ps
// Testbench-side notes for the channel interfaces of the running LCM block.
// The interfaces themselves come from rtl/rlcm_in_if.sv and rtl/rlcm_out_if.sv.
package tb_lcm_consts_pkg;
  localparam int unsigned SLOW_ITEM_CYCLES = 20000;
endpackage

/* test/tb.sv */
`timescale 1ns / 100ps
// Testbench of running_lcm_of_periods_core: a queue-fed driver sends period
// items, a predictor computes each run's LCM result, a monitor compares it.
// Depends on rlcm_pkg, tb_lcm_consts_pkg, rlcm_in_if, rlcm_out_if and the block.
module tb;
  import rlcm_pkg::*;
  import tb_lcm_consts_pkg::*;

  typedef struct packed {
    logic signed [31:0] period;
    logic [7:0] scale;
    logic last_item;
  } period_item_t;

  typedef struct packed {
    logic [62:0] recur_days;
    logic [8:0] items_used;
    logic overflowed;
  } lcm_result_t;

  localparam longint unsigned CYCLE_LIMIT = 64'd2500 * SLOW_ITEM_CYCLES;

  logic clk;
  logic rst_n;
  rlcm_in_if in_ch();
  rlcm_out_if out_ch();

  running_lcm_of_periods_core u_top(.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  period_item_t pending_items[$];
  lcm_result_t expected_lcms[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_sender = 0;
  longint unsigned clk_ticks = 0;

  logic [63:0] run_plain, run_promoted;
  bit run_hundredths, run_ovf_plain, run_ovf_promoted;
  int unsigned run_count;

  function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = b;
      b = a % b;
      a = t;
    end
    return a;
  endfunction

  task automatic fold_lcm(inout logic [63:0] acc, inout bit ovf, input logic [63:0] v);
    logic [63:0] g, q;
    if (ovf) return;
    if (acc == 0) begin
      acc = v;
      return;
    end
    g = gcd64(acc, v);
    if (g == 0) g = 1;
    q = acc / g;
    if (q > {1'b0, LCM_MAX} / v) begin
      acc = {1'b0, LCM_MAX};
      ovf = 1;
      return;
    end
    acc = q * v;
  endtask

  task automatic clear_run();
    run_plain = 0;
    run_promoted = 0;
    run_hundredths = 0;
    run_ovf_plain = 0;
    run_ovf_promoted = 0;
    run_count = 0;
  endtask

  task automatic predict_lcm(input period_item_t it);
    logic [63:0] p, lcm;
    bit ovf;
    lcm_result_t r;
    if (it.scale == SCALE_HUNDREDTHS) run_hundredths = 1;
    if (run_count < MAX_ITEMS) begin
      p = (it.period <= 0) ? 64'd1 : {32'd0, it.period};
      fold_lcm(run_plain, run_ovf_plain, p);
      fold_lcm(run_promoted, run_ovf_promoted, it.scale == SCALE_DAYS ? p * HUNDRED : p);
      run_count++;
    end
    if (!it.last_item) return;
    if (run_hundredths) begin
      ovf = run_ovf_promoted;
      lcm = run_promoted / HUNDRED;
    end else begin
      ovf = run_ovf_plain;
      lcm = run_plain;
    end
    if (ovf) lcm = {1'b0, LCM_MAX};
    r.recur_days = lcm[62:0];
    r.items_used = run_count[8:0];
    r.overflowed = ovf;
    expected_lcms.push_back(r);
    clear_run();
  endtask

  task automatic add_item(input logic [31:0] period, input logic [7:0] scale, input bit last);
    period_item_t it;
    it.period = period;
    it.scale = scale;
    it.last_item = last;
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] rand_period();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 55) return $urandom_range(1, 60);
    if (k < 70) return $urandom_range(61, 5000);
    if (k < 80) return $urandom_range(0, 1) ? 32'd0 : $urandom | 32'h8000_0000;
    if (k < 92) return $urandom_range(5001, 1000000);
    return $urandom;
  endfunction

  function automatic logic [7:0] rand_scale();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 4) return SCALE_DAYS;
    if (k < 7) return SCALE_HUNDREDTHS;
    return $urandom_range(0, 255);
  endfunction

  task automatic add_random_run();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 6);
    for (int i = 0; i < n; i++) add_item(rand_period(), rand_scale(), i == n - 1);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_lcms.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    clk_ticks <= clk_ticks + 1;
    if (clk_ticks > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_lcm(pending_items.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
      end else if (pending_items.size() != 0 && !hold_sender &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        in_ch.valid <= 1;
        in_ch.period <= pending_items[0].period;
        in_ch.scale <= pending_items[0].scale;
        in_ch.last_item <= pending_items[0].last_item;
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  always @(posedge clk) begin
    lcm_result_t e;
    if (!rst_n) begin
      out_ch.ready <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_lcms.size() == 0) begin
          $display("%0t: unexpected result lcm=%0d items=%0d ovf=%0b", $time,
                   out_ch.recur_days, out_ch.items_used, out_ch.overflowed);
          errors++;
        end else begin
          e = expected_lcms.pop_front();
          if (out_ch.recur_days !== e.recur_days) begin
            $display("%0t: recur_days expected %0d actual %0d", $time, e.recur_days,
                     out_ch.recur_days);
            errors++;
          end
          if (out_ch.items_used !== e.items_used) begin
            $display("%0t: items_used expected %0d actual %0d", $time, e.items_used,
                     out_ch.items_used);
            errors++;
          end
          if (out_ch.overflowed !== e.overflowed) begin
            $display("%0t: overflowed expected %0b actual %0b", $time, e.overflowed,
                     out_ch.overflowed);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    in_ch.valid = 0;
    in_ch.period = 0;
    in_ch.scale = 0;
    in_ch.last_item = 0;
    out_ch.ready = 0;
    rst_n = 0;
    clear_run();
    repeat (6) @(posedge clk);
    rst_n <= 1;

    send_idle_pct = 12;
    recv_idle_pct = 47;
    add_item(32'h7FFF_FFFF, SCALE_DAYS, 1);
    add_item(32'h8000_0000, SCALE_HUNDREDTHS, 1);
    add_item(0, 8'hFF, 1);
    add_item(4, SCALE_DAYS, 0);
    add_item(6, SCALE_DAYS, 1);
    add_item(150, SCALE_HUNDREDTHS, 0);
    add_item(3, SCALE_DAYS, 1);
    add_item(32'h7FFF_FFFF, 8'd0, 0);
    add_item(32'h7FFF_FFFE, 8'd0, 0);
    add_item(32'h7FFF_FFFD, 8'd0, 1);
    add_item(32'hFFFF_FFFF, SCALE_DAYS, 1);
    for (int i = 0; i < 18; i++) add_item(i + 2, i == 17 ? SCALE_HUNDREDTHS : SCALE_DAYS, i == 17);
    wait_drained();

    hold_sender = 1;
    add_random_run();
    repeat (40) @(posedge clk);
    hold_sender = 0;
    while (pending_items.size() < 250) add_random_run();
    wait_drained();

    send_idle_pct = 47;
    recv_idle_pct = 12;
    while (pending_items.size() < 250) add_random_run();
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (pending_items.size() < 250) add_random_run();
    wait_drained();
    repeat (20000) @(posedge clk);
    if (errors == 0 && expected_lcms.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
